@@ hw/rtl/emc_pkg.sv @@
// ----------------------------------------------------------------------------
// emc_pkg
// Shared widths, register map, reset values and unit request and response
// types for the EMG to motor command shaper.
// ----------------------------------------------------------------------------
package emc_pkg;

  // Field widths
  localparam int unsigned LVL_W  = 10;   // EMG level and thresholds
  localparam int unsigned CMD_W  = 16;   // motor command and step sizes
  localparam int unsigned PROD_W = 2 * CMD_W;

  // Stream payload packing
  localparam int unsigned S_TDATA_W = 24;  // close, open, stop, zero pad
  localparam int unsigned M_TDATA_W = 24;  // command, direction, zero pad

  // Configuration port
  localparam int unsigned APB_AW  = 5;
  localparam int unsigned APB_DW  = 32;
  localparam int unsigned REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_CLOSE_MIN   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_CLOSE_MAX   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_OPEN_MIN    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_OPEN_MAX    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_MAX_COMMAND = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_ACCEL_STEP  = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_DECEL_STEP  = 3'd6;

  // Register reset values
  localparam logic [LVL_W-1:0] RST_CLOSE_MIN   = 10'd100;
  localparam logic [LVL_W-1:0] RST_CLOSE_MAX   = 10'd800;
  localparam logic [LVL_W-1:0] RST_OPEN_MIN    = 10'd100;
  localparam logic [LVL_W-1:0] RST_OPEN_MAX    = 10'd800;
  localparam logic [CMD_W-1:0] RST_MAX_COMMAND = 16'd255;
  localparam logic [CMD_W-1:0] RST_ACCEL_STEP  = 16'd10;
  localparam logic [CMD_W-1:0] RST_DECEL_STEP  = 16'd0;

  // Direction codes
  localparam logic DIR_OPEN  = 1'b0;
  localparam logic DIR_CLOSE = 1'b1;

  // Request to the serial multiply-divide unit: q = floor(a*b/d)
  typedef struct packed {
    logic             start;
    logic [CMD_W-1:0] a;
    logic [CMD_W-1:0] b;
    logic [CMD_W-1:0] d;
  } md_req_t;

  // Response from the serial multiply-divide unit
  typedef struct packed {
    logic             done;
    logic [CMD_W-1:0] q;
  } md_rsp_t;

endpackage

@@ hw/rtl/emc_muldiv.sv @@
// ----------------------------------------------------------------------------
// emc_muldiv
// Bit-serial unit computing floor(a*b/d): a shift-add multiply, one
// multiplier bit per cycle, then a restoring divide, one quotient bit per
// cycle, both working in one shared product/quotient shift register.
// ----------------------------------------------------------------------------
module emc_muldiv (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  emc_pkg::md_req_t req_i,
  output emc_pkg::md_rsp_t rsp_o
);

  localparam int unsigned CW        = emc_pkg::CMD_W;
  localparam int unsigned PW        = emc_pkg::PROD_W;
  localparam int unsigned MUL_STEPS = CW;
  localparam int unsigned TOT_STEPS = CW + PW;
  localparam int unsigned CNT_W     = $clog2(TOT_STEPS);

  localparam logic [CNT_W-1:0] MUL_END  = CNT_W'(MUL_STEPS);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(TOT_STEPS - 1);

  logic [PW-1:0]    prod_q, prod_d;
  logic [CW-1:0]    rem_q, rem_d;
  logic [CW-1:0]    a_q, a_d;
  logic [CW-1:0]    d_q, d_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;

  // Step the multiply, then the divide
  always_comb begin
    logic [CW:0] sum;
    logic [CW:0] shifted;
    logic [CW:0] diff;
    logic        qbit;
    prod_d  = prod_q;
    rem_d   = rem_q;
    a_d     = a_q;
    d_d     = d_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    sum     = '0;
    shifted = '0;
    diff    = '0;
    qbit    = 1'b0;
    if (req_i.start) begin
      prod_d = {{CW{1'b0}}, req_i.b};
      rem_d  = '0;
      a_d    = req_i.a;
      d_d    = req_i.d;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (cnt_q < MUL_END) begin
        // add the multiplicand into the upper half, shift right
        sum    = {1'b0, prod_q[PW-1:CW]} + (prod_q[0] ? {1'b0, a_q} : '0);
        prod_d = {sum, prod_q[CW-1:1]};
      end else begin
        // bring in the next dividend bit, subtract where it fits
        shifted = {rem_q, prod_q[PW-1]};
        diff    = shifted - {1'b0, d_q};
        if (shifted >= {1'b0, d_q}) begin
          rem_d = diff[CW-1:0];
          qbit  = 1'b1;
        end else begin
          rem_d = shifted[CW-1:0];
        end
        prod_d = {prod_q[PW-2:0], qbit};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LAST_CNT) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath shift registers
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    rem_q  <= rem_d;
    a_q    <= a_d;
    d_q    <= d_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.q    = prod_q[CW-1:0];

endmodule

@@ hw/rtl/emg_to_motor_command_core.sv @@
// ----------------------------------------------------------------------------
// emg_to_motor_command_core
// Turns averaged open/close EMG levels into a shaped, slew-limited motor
// command and direction.
// ----------------------------------------------------------------------------
// Usage:
//   Input transactions on s_axis carry one close level, one open level and a
//   stop flag. Each yields exactly one output transaction on m_axis with the
//   motor command and direction. The user sets registers over the APB port
//   while the block is idle, unenforced by the block; pready is always high.
//   One item is worked on at a time. An active item runs two passes of the
//   bit-serial multiply-divide unit (remap, then squaring), each made of a
//   start state, the unit's shift steps and a wait state that collects the
//   quotient; the slew state then loads the result into the output register,
//   which raises m_axis_tvalid. A zero full scale skips the squaring pass; an
//   item whose stronger level lies below its threshold, or with an empty remap
//   range, skips the unit and goes straight to the slew state.
//   The output register lets the next item be accepted and worked on while a
//   result still waits; if the receiver stalls, the finished next result is
//   held until the output register frees, and s_axis_tready stays low.
//   Reset clears the last command to zero, the direction to close and loads
//   the register defaults.
// ----------------------------------------------------------------------------
module emg_to_motor_command_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // close level [9:0], open level [19:10], force_stop [20], zero [23:21]
  input  logic [emc_pkg::S_TDATA_W-1:0]    s_axis_tdata,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // motor_command [15:0], motor_direction [16], zero [23:17]
  output logic [emc_pkg::M_TDATA_W-1:0]    m_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [emc_pkg::APB_AW-1:0]       paddr,
  input  logic [emc_pkg::APB_DW-1:0]       pwdata,
  output logic [emc_pkg::APB_DW-1:0]       prdata,
  output logic                             pready
);

  localparam int unsigned LW = emc_pkg::LVL_W;
  localparam int unsigned CW = emc_pkg::CMD_W;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_REMAP  = 3'd1;
  localparam logic [2:0] ST_RWAIT  = 3'd2;
  localparam logic [2:0] ST_SQUARE = 3'd3;
  localparam logic [2:0] ST_SWAIT  = 3'd4;
  localparam logic [2:0] ST_SLEW   = 3'd5;

  // Configuration registers
  logic [LW-1:0] close_min_q, close_max_q, open_min_q, open_max_q;
  logic [CW-1:0] max_cmd_q, accel_q, decel_q;

  logic [emc_pkg::REG_IDX_W-1:0] reg_idx;
  logic                          reg_wr;

  assign reg_idx = paddr[emc_pkg::APB_AW-1:2];
  assign reg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  // Write the addressed register; ignore addresses beyond the map
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      close_min_q <= emc_pkg::RST_CLOSE_MIN;
      close_max_q <= emc_pkg::RST_CLOSE_MAX;
      open_min_q  <= emc_pkg::RST_OPEN_MIN;
      open_max_q  <= emc_pkg::RST_OPEN_MAX;
      max_cmd_q   <= emc_pkg::RST_MAX_COMMAND;
      accel_q     <= emc_pkg::RST_ACCEL_STEP;
      decel_q     <= emc_pkg::RST_DECEL_STEP;
    end else if (reg_wr) begin
      case (reg_idx)
        emc_pkg::REG_CLOSE_MIN:   close_min_q <= pwdata[LW-1:0];
        emc_pkg::REG_CLOSE_MAX:   close_max_q <= pwdata[LW-1:0];
        emc_pkg::REG_OPEN_MIN:    open_min_q  <= pwdata[LW-1:0];
        emc_pkg::REG_OPEN_MAX:    open_max_q  <= pwdata[LW-1:0];
        emc_pkg::REG_MAX_COMMAND: max_cmd_q   <= pwdata[CW-1:0];
        emc_pkg::REG_ACCEL_STEP:  accel_q     <= pwdata[CW-1:0];
        emc_pkg::REG_DECEL_STEP:  decel_q     <= pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (reg_idx)
      emc_pkg::REG_CLOSE_MIN:   prdata = emc_pkg::APB_DW'(close_min_q);
      emc_pkg::REG_CLOSE_MAX:   prdata = emc_pkg::APB_DW'(close_max_q);
      emc_pkg::REG_OPEN_MIN:    prdata = emc_pkg::APB_DW'(open_min_q);
      emc_pkg::REG_OPEN_MAX:    prdata = emc_pkg::APB_DW'(open_max_q);
      emc_pkg::REG_MAX_COMMAND: prdata = emc_pkg::APB_DW'(max_cmd_q);
      emc_pkg::REG_ACCEL_STEP:  prdata = emc_pkg::APB_DW'(accel_q);
      emc_pkg::REG_DECEL_STEP:  prdata = emc_pkg::APB_DW'(decel_q);
      default:                  prdata = '0;
    endcase
  end

  // Unpack the input transaction and pick the stronger channel
  logic [LW-1:0] in_close, in_open;
  logic          force_stop;
  logic          quiet, sel_close, remap_zero;
  logic [LW-1:0] lvl, lvl_lo, lvl_hi, lvl_clamped;

  assign in_close   = s_axis_tdata[LW-1:0];
  assign in_open    = s_axis_tdata[2*LW-1:LW];
  assign force_stop = s_axis_tdata[2*LW];

  assign quiet       = (in_close < close_min_q) && (in_open < open_min_q);
  assign sel_close   = in_close > in_open;
  assign lvl         = sel_close ? in_close    : in_open;
  assign lvl_lo      = sel_close ? close_min_q : open_min_q;
  assign lvl_hi      = sel_close ? close_max_q : open_max_q;
  assign remap_zero  = (lvl < lvl_lo) || (lvl_hi <= lvl_lo);
  assign lvl_clamped = (lvl > lvl_hi) ? lvl_hi : lvl;

  // Item state
  logic [2:0]    state_q, state_d;
  logic [LW-1:0] span_q, span_d, ofs_q, ofs_d;
  logic [CW-1:0] cmd_q, cmd_d;
  logic          stop_q, stop_d, dir_q, dir_d;
  logic [CW-1:0] last_cmd_q, last_cmd_d;
  logic          last_dir_q, last_dir_d;
  logic [CW-1:0] out_cmd_q, out_cmd_d;
  logic          out_dir_q, out_dir_d;
  logic          m_valid_q, m_valid_d;

  emc_pkg::md_req_t md_req;
  emc_pkg::md_rsp_t md_rsp;

  emc_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (md_req),
    .rsp_o  (md_rsp)
  );

  assign s_axis_tready = (state_q == ST_IDLE);

  // Slew window against the previous output
  logic [CW:0]   up_sum;
  logic [CW-1:0] win_hi, win_lo_raw, win_lo, slewed, result;

  assign up_sum     = {1'b0, last_cmd_q} + {1'b0, accel_q};
  assign win_hi     = (up_sum > {1'b0, max_cmd_q}) ? max_cmd_q : up_sum[CW-1:0];
  assign win_lo_raw = (last_cmd_q > decel_q) ? (last_cmd_q - decel_q) : '0;
  assign win_lo     = (win_lo_raw > win_hi) ? win_hi : win_lo_raw;
  assign slewed     = (cmd_q < win_lo) ? win_lo : ((cmd_q > win_hi) ? win_hi : cmd_q);
  assign result     = stop_q ? '0 : slewed;

  // Sequence one item through remap, squaring and slew limit
  always_comb begin
    state_d    = state_q;
    span_d     = span_q;
    ofs_d      = ofs_q;
    cmd_d      = cmd_q;
    stop_d     = stop_q;
    dir_d      = dir_q;
    last_cmd_d = last_cmd_q;
    last_dir_d = last_dir_q;
    out_cmd_d  = out_cmd_q;
    out_dir_d  = out_dir_q;
    m_valid_d  = m_valid_q;
    md_req     = '0;

    // drop the output once taken
    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          stop_d = force_stop;
          dir_d  = quiet ? last_dir_q
                         : (sel_close ? emc_pkg::DIR_CLOSE : emc_pkg::DIR_OPEN);
          ofs_d  = lvl_clamped - lvl_lo;
          span_d = lvl_hi - lvl_lo;
          cmd_d  = '0;
          state_d = (quiet || remap_zero) ? ST_SLEW : ST_REMAP;
        end
      end
      ST_REMAP: begin
        md_req.start = 1'b1;
        md_req.a     = CW'(ofs_q);
        md_req.b     = max_cmd_q;
        md_req.d     = CW'(span_q);
        state_d      = ST_RWAIT;
      end
      ST_RWAIT: begin
        if (md_rsp.done) begin
          if (max_cmd_q == '0) begin
            cmd_d   = '0;
            state_d = ST_SLEW;
          end else begin
            cmd_d   = md_rsp.q;
            state_d = ST_SQUARE;
          end
        end
      end
      ST_SQUARE: begin
        md_req.start = 1'b1;
        md_req.a     = cmd_q;
        md_req.b     = cmd_q;
        md_req.d     = max_cmd_q;
        state_d      = ST_SWAIT;
      end
      ST_SWAIT: begin
        if (md_rsp.done) begin
          cmd_d   = md_rsp.q;
          state_d = ST_SLEW;
        end
      end
      ST_SLEW: begin
        // hold the result until the output register is free
        if (!m_valid_q || m_axis_tready) begin
          out_cmd_d  = result;
          out_dir_d  = dir_q;
          m_valid_d  = 1'b1;
          last_cmd_d = result;
          last_dir_d = dir_q;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control state and history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      m_valid_q  <= 1'b0;
      last_cmd_q <= '0;
      last_dir_q <= emc_pkg::DIR_CLOSE;
    end else begin
      state_q    <= state_d;
      m_valid_q  <= m_valid_d;
      last_cmd_q <= last_cmd_d;
      last_dir_q <= last_dir_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    span_q    <= span_d;
    ofs_q     <= ofs_d;
    cmd_q     <= cmd_d;
    stop_q    <= stop_d;
    dir_q     <= dir_d;
    out_cmd_q <= out_cmd_d;
    out_dir_q <= out_dir_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(emc_pkg::M_TDATA_W - CW - 1){1'b0}}, out_dir_q, out_cmd_q};

endmodule

@@ hw/rtl/emc_checker.sv @@
// ----------------------------------------------------------------------------
// emc_checker
// Port-level checks for the EMG to motor command shaper, bound to the top.
// ----------------------------------------------------------------------------
module emc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [emc_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready
);

  logic       s_acc, m_acc;
  logic [1:0] pend_q;

  assign s_acc = s_axis_tvalid && s_axis_tready;
  assign m_acc = m_axis_tvalid && m_axis_tready;

  // Track items accepted but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + {1'b0, s_acc} - {1'b0, m_acc};
    end
  end

  // At most one item at work plus one waiting in the output register
  a_pending_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 2'd2)
    else $error("more than two items outstanding");

  // A result never appears without an item behind it
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (pend_q != 2'd0))
    else $error("output valid with no item outstanding");

  // One item at a time: ready drops after an input transaction
  a_one_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> !s_axis_tready)
    else $error("input accepted on consecutive cycles");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled output changed");

endmodule

bind emg_to_motor_command_core emc_checker u_emc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);
